/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define SC1KD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");
// The consequent must hold in the same cycle as the antecedent.
`define SC1KD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// The consequent must hold in the cycle after the antecedent.
`define SC1KD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SC1KD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SC1KD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SC1KD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/sc1kd_pkg.sv */
// ----------------------------------------------------------------------------
// Scan code set 1 decoder package
// Payload types, decoder state and the key lookup tables.
// ----------------------------------------------------------------------------
package sc1kd_pkg;

    localparam logic [7:0] BreakFlag  = 8'h80;
    localparam logic [7:0] PrefixByte = 8'hE0;
    localparam logic [7:0] PauseByte  = 8'hE1;
    localparam logic [6:0] PauseKey   = 7'd97;
    localparam logic [6:0] NoKey      = 7'd0;

    localparam logic [6:0] CodeCtrl   = 7'h1D;
    localparam logic [6:0] CodeLShift = 7'h2A;
    localparam logic [6:0] CodeRShift = 7'h36;
    localparam logic [6:0] CodeAlt    = 7'h38;
    localparam logic [6:0] CodeLGui   = 7'h5B;
    localparam logic [6:0] CodeRGui   = 7'h5C;

    localparam logic [2:0] ModLCtrl  = 3'd0;
    localparam logic [2:0] ModLShift = 3'd1;
    localparam logic [2:0] ModLAlt   = 3'd2;
    localparam logic [2:0] ModLGui   = 3'd3;
    localparam logic [2:0] ModRCtrl  = 3'd4;
    localparam logic [2:0] ModRShift = 3'd5;
    localparam logic [2:0] ModRAlt   = 3'd6;
    localparam logic [2:0] ModRGui   = 3'd7;

    typedef struct packed {
        logic [7:0] scan_byte;
    } t_scan_item;

    typedef struct packed {
        logic [6:0] key_number;
        logic       pressed;
        logic [7:0] modifier_map;
    } t_key_event;

    typedef struct packed {
        logic       prefix_pending;
        logic [1:0] pause_left;
        logic       pause_pressed;
        logic [7:0] held_modifiers;
    } t_dec_state;

    typedef struct packed {
        logic       hit;
        logic [2:0] bit_idx;
    } t_mod_hit;

    function automatic t_mod_hit modifier_lookup(input logic [6:0] code, input logic ext);
        t_mod_hit res;
        res.hit = 1'b1;
        res.bit_idx = ModLCtrl;
        if (ext) begin
            unique case (code)
                CodeCtrl: res.bit_idx = ModRCtrl;
                CodeAlt:  res.bit_idx = ModRAlt;
                CodeLGui: res.bit_idx = ModLGui;
                CodeRGui: res.bit_idx = ModRGui;
                default:  res.hit = 1'b0;
            endcase
        end else begin
            unique case (code)
                CodeCtrl:   res.bit_idx = ModLCtrl;
                CodeLShift: res.bit_idx = ModLShift;
                CodeRShift: res.bit_idx = ModRShift;
                CodeAlt:    res.bit_idx = ModLAlt;
                default:    res.hit = 1'b0;
            endcase
        end
        return res;
    endfunction

    // Normal keys are numbered densely in make-code order, skipping the gaps
    // left by the modifier codes and the unused codes.
    function automatic logic [6:0] normal_key(input logic [6:0] code);
        logic [6:0] key;
        key = NoKey;
        priority if (code >= 7'h01 && code <= 7'h1C) begin
            key = code;
        end else if (code >= 7'h1E && code <= 7'h29) begin
            key = code - 7'd1;
        end else if (code >= 7'h2B && code <= 7'h35) begin
            key = code - 7'd2;
        end else if (code == 7'h37) begin
            key = code - 7'd3;
        end else if (code >= 7'h39 && code <= 7'h53) begin
            key = code - 7'd4;
        end else if (code >= 7'h56 && code <= 7'h58) begin
            key = code - 7'd6;
        end else begin
            key = NoKey;
        end
        return key;
    endfunction

    function automatic logic [6:0] extended_key(input logic [6:0] code);
        logic [6:0] key;
        unique case (code)
            7'h1C:   key = 7'd83;
            7'h35:   key = 7'd84;
            7'h37:   key = 7'd85;
            7'h47:   key = 7'd86;
            7'h48:   key = 7'd87;
            7'h49:   key = 7'd88;
            7'h4B:   key = 7'd89;
            7'h4D:   key = 7'd90;
            7'h4F:   key = 7'd91;
            7'h50:   key = 7'd92;
            7'h51:   key = 7'd93;
            7'h52:   key = 7'd94;
            7'h53:   key = 7'd95;
            7'h5D:   key = 7'd96;
            default: key = NoKey;
        endcase
        return key;
    endfunction

endpackage

/* src/sc1kd_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type T per beat from a source to a sink.
// ----------------------------------------------------------------------------
interface sc1kd_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/sc1kd_decode.sv */
// ----------------------------------------------------------------------------
// Scan code decode step
// Combinational next state and event for one scan byte.
// ----------------------------------------------------------------------------
module sc1kd_decode #(
    parameter int PAUSE_TAIL = 2
) (
    input  logic [7:0]             i_byte,
    input  sc1kd_pkg::t_dec_state  i_state,
    output sc1kd_pkg::t_dec_state  o_state,
    output logic                   o_event_valid,
    output sc1kd_pkg::t_key_event  o_event
);
    localparam logic [1:0] TailCode = 2'(PAUSE_TAIL);

    logic [6:0]          code;
    logic                down;
    logic                ext;
    logic [1:0]          pause_next;
    logic                pause_press;
    logic [6:0]          key;
    sc1kd_pkg::t_mod_hit mod;

    assign code        = i_byte[6:0];
    assign down        = (i_byte & sc1kd_pkg::BreakFlag) == 8'h00;
    assign ext         = i_state.prefix_pending;
    assign pause_next  = i_state.pause_left - 2'd1;
    assign pause_press = (i_state.pause_left == TailCode) ? down : i_state.pause_pressed;
    assign mod         = sc1kd_pkg::modifier_lookup(code, ext);
    assign key         = ext ? sc1kd_pkg::extended_key(code) : sc1kd_pkg::normal_key(code);

    always_comb begin
        o_state                = i_state;
        o_event_valid          = 1'b0;
        o_event.key_number     = key;
        o_event.pressed        = down;
        o_event.modifier_map   = i_state.held_modifiers;
        priority if (i_state.pause_left != 2'd0) begin
            // Inside the pause sequence every byte is swallowed.
            o_state.pause_left    = pause_next;
            o_state.pause_pressed = pause_press;
            o_event.key_number    = sc1kd_pkg::PauseKey;
            o_event.pressed       = pause_press;
            o_event_valid         = pause_next == 2'd0;
        end else if (i_byte == sc1kd_pkg::PauseByte) begin
            o_state.pause_left = TailCode;
        end else if (i_byte == sc1kd_pkg::PrefixByte) begin
            o_state.prefix_pending = 1'b1;
        end else begin
            o_state.prefix_pending = 1'b0;
            if (mod.hit) begin
                o_state.held_modifiers[mod.bit_idx] = down;
            end else begin
                o_event_valid = key != sc1kd_pkg::NoKey;
            end
        end
    end
endmodule

/* src/scan_code_set1_key_decoder_top.sv */
// ----------------------------------------------------------------------------
// Scan code set 1 key decoder
// Turns keyboard scan bytes into key events with the held modifier map.
// ----------------------------------------------------------------------------
// The decoder takes one scan byte per clock as long as the result register is
// free or its event is being taken. A byte goes into the input register, is
// decoded there against the prefix, pause and modifier state, and its event,
// if any, is written to the result register when that register is free or
// its event is being taken. Prefix bytes, pause bytes and modifier codes
// change state only and give no event. Throughput is one byte per cycle while
// the result register is free or drains. The input stalls only when the input
// register holds a byte and the result holds an event that is not being taken.
`include "assert_macros.svh"

module scan_code_set1_key_decoder_top #(
    parameter int PAUSE_TAIL = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sc1kd_stream_if.sink          i_scan,
    sc1kd_stream_if.source        o_event
);
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    sc1kd_pkg::t_dec_state r_state;
    sc1kd_pkg::t_dec_state n_state;
    logic                  r_out_valid;
    sc1kd_pkg::t_key_event r_out;
    sc1kd_pkg::t_key_event n_out;
    logic                  n_out_valid;
    logic                  adv;
    sc1kd_pkg::t_scan_item in_item;

    assign in_item      = i_scan.data;
    // The decode stage moves whenever the result register is free or drains.
    assign adv          = !r_out_valid || o_event.ready;
    assign i_scan.ready = !r_in_valid || adv;

    sc1kd_decode #(
        .PAUSE_TAIL (PAUSE_TAIL)
    ) u_decode (
        .i_byte        (r_in_byte),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_event_valid (n_out_valid),
        .o_event       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_scan.ready) begin
                r_in_valid <= i_scan.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && n_out_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.ready && i_scan.valid) begin
            r_in_byte <= in_item.scan_byte;
        end
        if (adv && r_in_valid && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_event.valid = r_out_valid;
    assign o_event.data  = r_out;

    `SC1KD_ASSERT_IMPL(a_key_in_range, i_clk, i_rst_n, r_out_valid, r_out.key_number != sc1kd_pkg::NoKey && r_out.key_number <= sc1kd_pkg::PauseKey)
    `SC1KD_ASSERT_ALWAYS(a_pause_bound, i_clk, i_rst_n, r_state.pause_left <= 2'(PAUSE_TAIL))
    `SC1KD_ASSERT_IMPL(a_pause_last, i_clk, i_rst_n, adv && r_in_valid && n_out_valid && r_state.pause_left != 2'd0, r_state.pause_left == 2'd1)
    `SC1KD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_byte))
endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Scan code set 1 key decoder testbench
// Sends scan bytes over the input stream and checks every key event against
// a decoder model that tracks the prefix, pause and modifier state on its
// own. Directed byte sequences come first, then random key strokes, modifier
// changes, extended codes, pause sequences and noise. Both sides idle at
// random, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PauseTail     = 2;
    localparam logic [1:0] PauseLen      = 2'(PauseTail);
    localparam int         RandomBytes   = 610;
    localparam int         QuietTail     = 80;
    localparam int         NumDirected   = 38;
    localparam int         NumExtCodes   = 14;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sc1kd_stream_if #(.T(sc1kd_pkg::t_scan_item)) scan_if ();
    sc1kd_stream_if #(.T(sc1kd_pkg::t_key_event)) event_if ();

    scan_code_set1_key_decoder_top #(
        .PAUSE_TAIL(PauseTail)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_scan (scan_if.sink),
        .o_event(event_if.source)
    );

    // Model state of the decoder.
    logic       ext_armed = 1'b0;
    logic [1:0] pause_count = 2'd0;
    logic       pause_down = 1'b0;
    logic [7:0] mods_held = 8'h00;

    logic [7:0]            pending_bytes[$];
    sc1kd_pkg::t_key_event expected_events[$];
    int         errors = 0;
    logic       tail_quiet = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;

    logic [7:0] directed_bytes [NumDirected] = '{
        8'h00, 8'hFF, 8'h01, 8'h58, 8'hD8, 8'h59,
        8'h1D, 8'h2A, 8'h36, 8'h38, 8'h1C, 8'h9D, 8'hAA,
        8'hE0, 8'h1D, 8'hE0, 8'h38, 8'hE0, 8'h5B, 8'hE0, 8'h5C,
        8'hE0, 8'h1C, 8'hE0, 8'h2A,
        8'hE0, 8'hE0, 8'h48,
        8'hE1, 8'h9D, 8'hC5,
        8'hE1, 8'hE0, 8'hE1,
        8'hE0, 8'hE1, 8'h1D, 8'h45
    };

    logic [6:0] ext_codes [NumExtCodes] = '{
        7'h1C, 7'h35, 7'h37, 7'h47, 7'h48, 7'h49, 7'h4B,
        7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5D
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advances the model by one accepted byte and queues the event it gives.
    task automatic decode_scan_byte(input logic [7:0] scan_value);
        logic [6:0]            code;
        logic                  down;
        logic                  is_mod;
        logic [2:0]            mod_idx;
        logic [6:0]            key;
        sc1kd_pkg::t_key_event ev;
        code = scan_value[6:0];
        down = ~scan_value[7];
        is_mod = 1'b1;
        mod_idx = sc1kd_pkg::ModLCtrl;
        key = sc1kd_pkg::NoKey;
        if (pause_count != 2'd0) begin
            // The first byte after the pause byte decides press or release.
            if (pause_count == PauseLen) begin
                pause_down = down;
            end
            pause_count = pause_count - 2'd1;
            if (pause_count == 2'd0) begin
                ev.key_number = sc1kd_pkg::PauseKey;
                ev.pressed = pause_down;
                ev.modifier_map = mods_held;
                expected_events.push_back(ev);
            end
        end else if (scan_value == sc1kd_pkg::PauseByte) begin
            pause_count = PauseLen;
        end else if (scan_value == sc1kd_pkg::PrefixByte) begin
            ext_armed = 1'b1;
        end else begin
            if (ext_armed) begin
                case (code)
                    sc1kd_pkg::CodeCtrl: mod_idx = sc1kd_pkg::ModRCtrl;
                    sc1kd_pkg::CodeAlt:  mod_idx = sc1kd_pkg::ModRAlt;
                    sc1kd_pkg::CodeLGui: mod_idx = sc1kd_pkg::ModLGui;
                    sc1kd_pkg::CodeRGui: mod_idx = sc1kd_pkg::ModRGui;
                    default:             is_mod = 1'b0;
                endcase
            end else begin
                case (code)
                    sc1kd_pkg::CodeCtrl:   mod_idx = sc1kd_pkg::ModLCtrl;
                    sc1kd_pkg::CodeLShift: mod_idx = sc1kd_pkg::ModLShift;
                    sc1kd_pkg::CodeRShift: mod_idx = sc1kd_pkg::ModRShift;
                    sc1kd_pkg::CodeAlt:    mod_idx = sc1kd_pkg::ModLAlt;
                    default:               is_mod = 1'b0;
                endcase
            end
            if (is_mod) begin
                mods_held[mod_idx] = down;
            end else begin
                if (ext_armed) begin
                    for (int k = 0; k < NumExtCodes; k++) begin
                        if (ext_codes[k] == code) begin
                            key = 7'(83 + k);
                        end
                    end
                end else if (code >= 7'h01 && code <= 7'h1C) begin
                    key = code;
                end else if (code >= 7'h1E && code <= 7'h29) begin
                    key = code - 7'd1;
                end else if (code >= 7'h2B && code <= 7'h35) begin
                    key = code - 7'd2;
                end else if (code == 7'h37) begin
                    key = 7'd52;
                end else if (code >= 7'h39 && code <= 7'h53) begin
                    key = code - 7'd4;
                end else if (code >= 7'h56 && code <= 7'h58) begin
                    key = code - 7'd6;
                end
                if (key != sc1kd_pkg::NoKey) begin
                    ev.key_number = key;
                    ev.pressed = down;
                    ev.modifier_map = mods_held;
                    expected_events.push_back(ev);
                end
            end
            ext_armed = 1'b0;
        end
    endtask

    // Driver: one beat per accepted byte, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_if.valid <= 1'b0;
            tail_quiet <= 1'b0;
        end else begin
            tail_quiet <= (pending_bytes.size() <= QuietTail);
            if (scan_if.valid && scan_if.ready) begin
                decode_scan_byte(scan_if.data.scan_byte);
            end
            if (!scan_if.valid || scan_if.ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    scan_if.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    scan_if.valid <= 1'b0;
                end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    scan_if.valid <= 1'b0;
                end else begin
                    scan_if.valid <= 1'b1;
                    scan_if.data.scan_byte <= pending_bytes.pop_front();
                end
            end
        end
    end

    // Monitor: checks each event beat and applies random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            event_if.ready <= 1'b0;
        end else begin
            if (event_if.valid && event_if.ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected key event: key_number %0d pressed %0d modifier_map %h",
                           event_if.data.key_number, event_if.data.pressed,
                           event_if.data.modifier_map);
                    errors = errors + 1;
                end else begin
                    sc1kd_pkg::t_key_event want;
                    want = expected_events.pop_front();
                    if (event_if.data.key_number !== want.key_number) begin
                        $error("key_number: expected %0d, actual %0d",
                               want.key_number, event_if.data.key_number);
                        errors = errors + 1;
                    end
                    if (event_if.data.pressed !== want.pressed) begin
                        $error("pressed: expected %0d, actual %0d",
                               want.pressed, event_if.data.pressed);
                        errors = errors + 1;
                    end
                    if (event_if.data.modifier_map !== want.modifier_map) begin
                        $error("modifier_map: expected %h, actual %h",
                               want.modifier_map, event_if.data.modifier_map);
                        errors = errors + 1;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                event_if.ready <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(0, 15);
                event_if.ready <= 1'b0;
            end else begin
                event_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int         pick;
        int         total;
        logic [6:0] code;
        scan_if.valid = 1'b0;
        scan_if.data = '0;
        event_if.ready = 1'b0;

        for (int k = 0; k < NumDirected; k++) begin
            pending_bytes.push_back(directed_bytes[k]);
        end
        // The prefix survives the pause sequence and applies to this code.
        pending_bytes.push_back(8'h48);
        pending_bytes.push_back(8'h7F);

        total = pending_bytes.size() + RandomBytes;
        while (pending_bytes.size() < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                code = 7'($urandom_range(1, 8'h58));
                pending_bytes.push_back({1'b0, code});
                if ($urandom_range(0, 3) != 0) begin
                    pending_bytes.push_back({1'b1, code});
                end
            end else if (pick < 50) begin
                case ($urandom_range(0, 7))
                    0: code = sc1kd_pkg::CodeCtrl;
                    1: code = sc1kd_pkg::CodeLShift;
                    2: code = sc1kd_pkg::CodeRShift;
                    3: code = sc1kd_pkg::CodeAlt;
                    4: code = sc1kd_pkg::CodeCtrl;
                    5: code = sc1kd_pkg::CodeAlt;
                    6: code = sc1kd_pkg::CodeLGui;
                    default: code = sc1kd_pkg::CodeRGui;
                endcase
                if (code == sc1kd_pkg::CodeLGui || code == sc1kd_pkg::CodeRGui
                        || $urandom_range(0, 2) == 0) begin
                    pending_bytes.push_back(sc1kd_pkg::PrefixByte);
                end
                pending_bytes.push_back({1'($urandom_range(0, 1)), code});
            end else if (pick < 70) begin
                pending_bytes.push_back(sc1kd_pkg::PrefixByte);
                if ($urandom_range(0, 1) == 0) begin
                    code = ext_codes[$urandom_range(0, NumExtCodes - 1)];
                end else begin
                    code = 7'($urandom_range(0, 127));
                end
                pending_bytes.push_back({1'($urandom_range(0, 1)), code});
            end else if (pick < 80) begin
                pending_bytes.push_back(sc1kd_pkg::PauseByte);
                case ($urandom_range(0, 2))
                    0: begin
                        pending_bytes.push_back(8'h1D);
                        pending_bytes.push_back(8'h45);
                    end
                    1: begin
                        pending_bytes.push_back(8'h9D);
                        pending_bytes.push_back(8'hC5);
                    end
                    default: begin
                        pending_bytes.push_back(8'($urandom_range(0, 255)));
                        pending_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end else begin
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || scan_if.valid) @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("** scan_code_set1_key_decoder_top: PASSED **");
        end else begin
            $display("** scan_code_set1_key_decoder_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** scan_code_set1_key_decoder_top: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/sc1kd_pkg.sv
src/sc1kd_stream_if.sv
src/sc1kd_decode.sv
src/scan_code_set1_key_decoder_top.sv
sim/tb_top.sv
